// ===== hw/rtl/lfbf_pkg.sv =====
// ----------------------------------------------------------------------------
// lfbf_pkg
// shared constants for the led frame blur and flash block
// ----------------------------------------------------------------------------
package lfbf_pkg;
    localparam int unsigned MaxPixels       = 256;
    localparam int unsigned FramesPerSecond = 30;
    localparam int unsigned CfgIdxW         = 3;
    localparam int unsigned CfgDataW        = 16;

    localparam logic [CfgIdxW-1:0] REG_FLASH_RATE  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PIXEL_COUNT = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_COLOR_GREEN = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_COLOR_RED   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_COLOR_BLUE  = 3'd4;

    localparam logic [7:0] LED_RESET = 8'h80;
    localparam logic [6:0] LEVEL_MASK = 7'h7f;
endpackage

// ===== hw/rtl/led_frame_blur_and_flash.sv =====
// ----------------------------------------------------------------------------
// led_frame_blur_and_flash
// led byte store with wrap-around 3-tap blur and random colour flashes
// ----------------------------------------------------------------------------
// render: a frame gap first resets the used bytes of the store, each byte is
//   then blurred, and rate/fps pixels flash, plus one more when rate mod fps
//   is nonzero and divides the frame number; a read returns the stored byte
// requests: one at a time, busy high until the result strobe
// reset: synchronous active low; after reset a clearing pass writes 0x80 to
//   all 3*MAX_PIXELS store bytes while busy stays high
// the receiver cannot stall: o_done is a single cycle strobe
module led_frame_blur_and_flash #(
    parameter int unsigned MAX_PIXELS        = lfbf_pkg::MaxPixels,
    parameter int unsigned FRAMES_PER_SECOND = lfbf_pkg::FramesPerSecond
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [lfbf_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [lfbf_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                          i_kind,
    input  logic [30:0]                   i_frame_number,
    input  logic [9:0]                    i_byte_index,
    output logic                          o_done,
    output logic [7:0]                    o_byte_value
);
    import lfbf_pkg::*;

    localparam int unsigned Depth = 3 * MAX_PIXELS;
    localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned PW    = $clog2(MAX_PIXELS + 1);
    localparam int unsigned LW    = $clog2(Depth + 1);
    // reciprocal of the frame rate, exact for any 16-bit rate
    localparam int unsigned RecipShift = 26;
    localparam logic [26:0] RecipK = 27'(((64'd1 << RecipShift)
        + 64'(FRAMES_PER_SECOND) - 64'd1) / 64'(FRAMES_PER_SECOND));

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD_WAIT, S_RD_OUT,
        S_RST, S_BL_L, S_BL_M, S_BL_R, S_BL_W1, S_BL_W2,
        S_REM, S_FL_DRAW, S_FL_MOD, S_FL_W0, S_FL_W1, S_FL_W2, S_DONE
    } t_state;

    t_state r_state;
    logic [7:0] mem [Depth];
    logic [7:0] r_rdata;

    logic [15:0] r_flashes_ps;
    logic [8:0]  r_pixel_count;
    logic [6:0]  r_g, r_r, r_b;

    logic [31:0] r_prev;       // signed previous frame
    logic [30:0] r_lfsr;
    logic [30:0] r_frame;
    logic [9:0]  r_idx;
    logic [AW-1:0] r_i;         // walk position
    logic [LW-1:0] r_len;
    logic [PW-1:0] r_npix;
    logic [8:0]  r_sum;
    logic [15:0] r_quot, r_remv;
    logic [15:0] r_quot_cnt;
    logic        r_extra;
    // bit-serial modulo
    logic [30:0] r_dvd;
    logic [15:0] r_dvs;
    logic [15:0] r_rem;
    logic [4:0]  r_bit;
    logic        r_mode_rem;    // 1: frame mod rem, 0: lfsr mod npix
    logic        r_busy, r_done;
    logic [7:0]  r_out;

    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [7:0]    mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    logic [15:0] rate;
    logic [42:0] quot_prod;
    logic        gap;
    logic [30:0] lfsr_nx;
    logic [16:0] trial;
    logic [AW-1:0] li, ri;
    logic [LW:0] ip3;

    assign rate  = (r_flashes_ps == 16'd0) ? 16'd1 : r_flashes_ps;
    assign quot_prod = 43'(rate) * 43'(RecipK);
    assign lfsr_nx = {r_lfsr[29:0], r_lfsr[30] ^ r_lfsr[27]};
    // delta > 1 with prev in 33-bit signed space
    assign gap = ($signed({2'b00, r_frame}) - $signed({r_prev[31], r_prev})) > 34'sd1;
    assign trial = {r_rem, r_dvd[30]} - {1'b0, r_dvs};
    assign ip3 = (LW+1)'(r_i) + (LW+1)'(3);
    assign ri  = (ip3 >= (LW+1)'(r_len)) ? AW'(ip3 - (LW+1)'(r_len)) : AW'(ip3);
    assign li  = ((LW)'(r_i) < LW'(3)) ? AW'((LW)'(r_i) + r_len - LW'(3)) : AW'(r_i - AW'(3));

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_i;
        mem_wd = LED_RESET;
        mem_ra = r_i;
        case (r_state)
            S_CLEAR:   mem_we = 1'b1;
            S_RST:     mem_we = gap;
            S_IDLE:    mem_ra = AW'(i_byte_index);
            S_RD_WAIT: mem_ra = AW'(r_idx);
            S_BL_L:    mem_ra = li;
            S_BL_M:    mem_ra = r_i;
            S_BL_R:    mem_ra = ri;
            S_BL_W2: begin
                mem_we = 1'b1;
                mem_wd = {1'b1, r_sum[8:2]};
            end
            S_FL_W0: begin mem_we = 1'b1; mem_wd = {1'b1, r_g}; end
            S_FL_W1: begin mem_we = 1'b1; mem_wd = {1'b1, r_r}; end
            S_FL_W2: begin mem_we = 1'b1; mem_wd = {1'b1, r_b}; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_i <= '0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_flashes_ps <= 16'd8;
            r_pixel_count <= 9'd256;
            r_g <= '0; r_r <= '0; r_b <= '0;
            r_prev <= '1;
            r_lfsr <= 31'd1;
            r_quot <= '0;
            r_remv <= '0;
        end else begin
            r_done <= 1'b0;
            // remainder is taken from the registered quotient; both settle long before use
            r_quot <= 16'(quot_prod >> RecipShift);
            r_remv <= 16'(32'(rate) - 32'(r_quot) * FRAMES_PER_SECOND);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FLASH_RATE:  r_flashes_ps  <= i_cfg_data;
                    REG_PIXEL_COUNT: r_pixel_count <= i_cfg_data[8:0];
                    REG_COLOR_GREEN: r_g <= i_cfg_data[6:0] & LEVEL_MASK;
                    REG_COLOR_RED:   r_r <= i_cfg_data[6:0] & LEVEL_MASK;
                    REG_COLOR_BLUE:  r_b <= i_cfg_data[6:0] & LEVEL_MASK;
                    default: ;
                endcase
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_i == AW'(Depth - 1)) begin
                        r_state <= S_IDLE;
                        r_busy <= 1'b0;
                    end else begin
                        r_i <= r_i + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_busy  <= 1'b1;
                        r_frame <= i_frame_number;
                        r_idx   <= i_byte_index;
                        if (i_kind) begin
                            r_state <= S_RD_WAIT;
                        end else begin
                            r_npix <= (r_pixel_count == 9'd0) ? PW'(1) :
                                (32'(r_pixel_count) > MAX_PIXELS) ? PW'(MAX_PIXELS) :
                                PW'(r_pixel_count);
                            r_i <= '0;
                            r_state <= S_RST;
                        end
                    end
                end
                S_RD_WAIT: r_state <= S_RD_OUT;
                S_RD_OUT: begin
                    r_out <= (32'(r_idx) < Depth) ? r_rdata : 8'd0;
                    r_state <= S_DONE;
                end
                S_RST: begin
                    // first cycle fixes length; writes only when gap
                    r_len <= LW'(3 * 32'(r_npix));
                    if (!gap || r_i == AW'(3 * 32'(r_npix) - 1)) begin
                        r_i <= '0;
                        r_state <= S_BL_L;
                    end else begin
                        r_i <= r_i + AW'(1);
                    end
                end
                S_BL_L: r_state <= S_BL_M;
                S_BL_M: begin
                    // left neighbour, already blurred unless it wrapped
                    r_sum <= {2'b00, r_rdata[6:0]};
                    r_state <= S_BL_R;
                end
                S_BL_R: begin
                    r_sum <= r_sum + {2'b00, r_rdata[6:0]};
                    r_state <= S_BL_W1;
                end
                S_BL_W1: begin
                    // a wrapped right neighbour is read back already blurred, unless it is the byte itself
                    r_sum <= r_sum + {2'b00, r_rdata[6:0]};
                    r_state <= S_BL_W2;
                end
                S_BL_W2: begin
                    if ((LW)'(r_i) == r_len - LW'(1)) begin
                        r_quot_cnt <= r_quot;
                        r_state <= S_REM;
                    end else begin
                        r_i <= r_i + AW'(1);
                        r_state <= S_BL_L;
                    end
                end
                S_REM: begin
                    r_extra <= 1'b0;
                    if (r_remv != 16'd0) begin
                        r_dvd <= r_frame; r_dvs <= r_remv; r_rem <= '0;
                        r_bit <= '0; r_mode_rem <= 1'b1;
                        r_state <= S_FL_MOD;
                    end else begin
                        r_state <= S_FL_DRAW;
                    end
                end
                S_FL_DRAW: begin
                    if (r_quot_cnt == 16'd0 && !r_extra) begin
                        r_prev <= {1'b0, r_frame};
                        r_out <= 8'd0;
                        r_state <= S_DONE;
                    end else begin
                        if (r_quot_cnt != 16'd0) r_quot_cnt <= r_quot_cnt - 16'd1;
                        else r_extra <= 1'b0;
                        r_lfsr <= lfsr_nx;
                        r_dvd <= lfsr_nx; r_dvs <= 16'(r_npix); r_rem <= '0;
                        r_bit <= '0; r_mode_rem <= 1'b0;
                        r_state <= S_FL_MOD;
                    end
                end
                S_FL_MOD: begin
                    r_rem <= trial[16] ? {r_rem[14:0], r_dvd[30]} : trial[15:0];
                    r_dvd <= {r_dvd[29:0], 1'b0};
                    r_bit <= r_bit + 5'd1;
                    if (r_bit == 5'd30) begin
                        if (r_mode_rem) begin
                            r_extra <= (trial[16] ? {r_rem[14:0], r_dvd[30]}
                                                  : trial[15:0]) == 16'd0;
                            r_state <= S_FL_DRAW;
                        end else begin
                            r_i <= AW'(3 * 32'(trial[16] ? {r_rem[14:0], r_dvd[30]}
                                                         : trial[15:0]));
                            r_state <= S_FL_W0;
                        end
                    end
                end
                S_FL_W0: begin r_i <= r_i + AW'(1); r_state <= S_FL_W1; end
                S_FL_W1: begin r_i <= r_i + AW'(1); r_state <= S_FL_W2; end
                S_FL_W2: r_state <= S_FL_DRAW;
                S_DONE: begin
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = r_busy;
    assign o_done = r_done;
    assign o_byte_value = r_out;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("busy at done");
    a_lfsr_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != 31'd0) else $error("lfsr stuck");
endmodule

// ===== tb/led_frame_blur_and_flash_tb.sv =====
// ----------------------------------------------------------------------------
// led_frame_blur_and_flash_tb
// drives render and read requests into the led frame block in bursts, keeps
// its own copy of the byte store, blur and flash generator, and compares every
// returned byte in order; register settings are changed only while idle
// ----------------------------------------------------------------------------
module led_frame_blur_and_flash_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lfbf_pkg::*;

    localparam int unsigned StoreBytes = 3 * MaxPixels;
    localparam longint unsigned CycleLimit = 6000000;

    // mirror of the block: byte store, frame history, flash generator
    class led_store_model;
        logic [7:0]  store [StoreBytes];
        longint      prev_frame_nr;
        logic [30:0] lfsr;
        logic [15:0] rate_setting;
        logic [8:0]  pixel_count;
        logic [6:0]  green, red, blue;
        logic [7:0]  pending_bytes [$];

        function void reset_state();
            foreach (store[i]) store[i] = LED_RESET;
            prev_frame_nr = -1;
            lfsr          = 31'd1;
            rate_setting  = 16'd8;
            pixel_count   = 9'd256;
            green         = '0;
            red           = '0;
            blue          = '0;
            pending_bytes.delete();
        endfunction

        function int unsigned pixels_used();
            int unsigned n;
            n = pixel_count;
            if (n == 0) n = 1;
            if (n > MaxPixels) n = MaxPixels;
            return n;
        endfunction

        function void flash_pixel(int unsigned npix);
            int unsigned b;
            lfsr = {lfsr[29:0], lfsr[30] ^ lfsr[27]};
            b = (int'(lfsr) % npix) * 3;
            store[b]     = {1'b1, green};
            store[b + 1] = {1'b1, red};
            store[b + 2] = {1'b1, blue};
        endfunction

        function void render(logic [30:0] frame);
            int unsigned npix, len, rate, quot, rem, li, ri, sum;
            npix = pixels_used();
            len  = npix * 3;
            rate = (rate_setting == 0) ? 1 : rate_setting;
            quot = rate / FramesPerSecond;
            rem  = rate % FramesPerSecond;
            if (longint'(frame) - prev_frame_nr > 1)
                for (int i = 0; i < len; i++) store[i] = LED_RESET;
            for (int unsigned i = 0; i < len; i++) begin
                li = (i + len - 3) % len;
                ri = (i + 3) % len;
                sum = (store[li] & LEVEL_MASK) + (store[i] & LEVEL_MASK)
                    + (store[ri] & LEVEL_MASK);
                store[i] = {1'b1, 7'(sum / 4)};
            end
            for (int unsigned i = 0; i < quot; i++) flash_pixel(npix);
            if (rem != 0 && (int'(frame) % rem) == 0) flash_pixel(npix);
            prev_frame_nr = longint'(frame);
        endfunction

        function void note_request(logic kind, logic [30:0] frame, logic [9:0] idx);
            if (kind == 1'b0) begin
                render(frame);
                pending_bytes.push_back(8'd0);
            end else begin
                pending_bytes.push_back((idx < StoreBytes) ? store[idx] : 8'd0);
            end
        endfunction

        // 0 match, 1 mismatch, 2 nothing waiting
        function int check_byte(logic [7:0] got, output logic [7:0] want);
            want = '0;
            if (pending_bytes.size() == 0) return 2;
            want = pending_bytes.pop_front();
            return (got === want) ? 0 : 1;
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;
    logic                i_kind;
    logic [30:0]         i_frame_number;
    logic [9:0]          i_byte_index;
    logic                o_done;
    logic [7:0]          o_byte_value;

    led_store_model model;
    int unsigned    errors;
    longint unsigned cycles;
    logic [30:0]    cur_frame;

    led_frame_blur_and_flash u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_frame_number (i_frame_number),
        .i_byte_index   (i_byte_index),
        .o_done         (o_done),
        .o_byte_value   (o_byte_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        errors++;
        $display("mismatch: %s got %02h want %02h at cycle %0d", what, got, want, cycles);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        logic [7:0] want;
        int         st;
        if (i_rst_n && o_done) begin
            st = model.check_byte(o_byte_value, want);
            if (st == 1) report("byte_value", o_byte_value, want);
            else if (st == 2) report("unexpected result", o_byte_value, want);
        end
    end

    // start stays high across back-to-back requests
    task automatic issue(logic kind, logic [30:0] frame, logic [9:0] idx);
        start          <= 1'b1;
        i_kind         <= kind;
        i_frame_number <= frame;
        i_byte_index   <= idx;
        do @(posedge i_clk); while (busy);
        model.note_request(kind, frame, idx);
    endtask

    task automatic pause(int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (model.pending_bytes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(logic [15:0] rate, logic [8:0] pix,
                              logic [6:0] g, logic [6:0] r, logic [6:0] b);
        logic [15:0] vals [5];
        drain();
        vals = '{rate, 16'(pix), 16'(g), 16'(r), 16'(b)};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CfgIdxW'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        model.rate_setting = rate;
        model.pixel_count  = pix;
        model.green        = g;
        model.red          = r;
        model.blue         = b;
    endtask

    task automatic next_frame(output logic [30:0] f);
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 13) f = cur_frame + 31'd1;
        else if (sel < 15) f = cur_frame;
        else if (sel < 17) f = cur_frame + 31'($urandom_range(2, 9));
        else if (sel < 18) f = cur_frame - 31'($urandom_range(1, 5));
        else f = 31'($urandom());
        cur_frame = f;
    endtask

    task automatic random_phase(int unsigned items, int unsigned render_pct);
        int unsigned left, burst, used;
        logic [30:0] f;
        logic [9:0]  idx;
        left = items;
        while (left > 0) begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && left > 0) begin
                if ($urandom_range(0, 99) < render_pct) begin
                    next_frame(f);
                    issue(1'b0, f, 10'($urandom()));
                end else begin
                    used = model.pixels_used() * 3;
                    if ($urandom_range(0, 4) == 0) idx = 10'($urandom());
                    else idx = 10'($urandom_range(0, used - 1));
                    issue(1'b1, 31'($urandom()), idx);
                end
                burst--;
                left--;
            end
            case ($urandom_range(0, 5))
                0: drain();
                1, 2: ;
                default: pause($urandom_range(1, 7));
            endcase
        end
    endtask

    initial begin
        model = new();
        model.reset_state();
        errors         = 0;
        cycles         = 0;
        cur_frame      = '0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        i_kind         = 1'b0;
        i_frame_number = '0;
        i_byte_index   = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: edges of the store and out-of-range reads
        issue(1'b1, 31'h7fffffff, 10'd0);
        issue(1'b1, 31'd0, 10'd767);
        issue(1'b1, 31'd0, 10'd768);
        issue(1'b1, 31'd0, 10'd1023);
        issue(1'b0, 31'd0, 10'd1023);
        issue(1'b0, 31'd1, 10'd0);
        issue(1'b0, 31'd1, 10'd0);
        issue(1'b1, 31'd0, 10'd3);
        // frame gap forces the store back to the reset level
        issue(1'b0, 31'd7, 10'd0);
        issue(1'b0, 31'h7fffffff, 10'd0);
        // going backwards never resets
        issue(1'b0, 31'd0, 10'd0);
        issue(1'b1, 31'd0, 10'd2);

        // zero rate and zero pixels, then full colour
        set_config(16'd0, 9'd0, 7'h7f, 7'h7f, 7'h7f);
        issue(1'b0, 31'd30, 10'd0);
        issue(1'b0, 31'd31, 10'd0);
        issue(1'b1, 31'd0, 10'd0);
        issue(1'b1, 31'd0, 10'd5);
        // pixel count above the store size saturates
        set_config(16'd29, 9'd511, 7'h00, 7'h55, 7'h2a);
        issue(1'b0, 31'd58, 10'd0);
        issue(1'b1, 31'd0, 10'd767);
        // largest rate on one pixel
        set_config(16'hffff, 9'd1, 7'h01, 7'h40, 7'h7f);
        issue(1'b0, 31'd0, 10'd0);
        issue(1'b1, 31'd0, 10'd0);
        issue(1'b1, 31'd0, 10'd1);
        issue(1'b1, 31'd0, 10'd2);
        drain();

        for (int p = 0; p < 8; p++) begin
            set_config(16'($urandom_range(0, 240)), 9'($urandom_range(1, 12)),
                       7'($urandom()), 7'($urandom()), 7'($urandom()));
            random_phase(28, 45);
        end
        set_config(16'hffff, 9'd2, 7'h7f, 7'h00, 7'h7f);
        random_phase(4, 50);
        set_config(16'd8, 9'd256, 7'h00, 7'h00, 7'h00);
        random_phase(6, 40);

        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && model.pending_bytes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
